/* hw/rtl/sdr_pkg.sv */
package sdr_pkg;

  // Field widths of the item and result channels.
  localparam int CNT_W     = 16;
  localparam int TOT_W     = 24;
  localparam int RICH_W    = 8;
  localparam int PROB_W    = 17;
  localparam int DRAW_W    = 16;
  localparam int CELL_IN_W = 7;
  localparam int SP_IN_W   = 7;

  // Default landscape dimensions.
  localparam int CELLS_DEF   = 128;
  localparam int SPECIES_DEF = 128;

  // Saturation limits of the counters.
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TOT_W-1:0]  TOT_MAX  = '1;
  localparam logic [RICH_W-1:0] RICH_MAX = '1;

  // Death probability after reset: 0.15 of 65536, rounded down.
  localparam logic [PROB_W-1:0] DEATH_PROB_RST = 17'd9830;

  // Item kinds.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_DEATH = 1'b1;

  // Control from the sequencer to the running-sum unit.
  typedef struct packed {
    logic start;
    logic step;
  } sdr_pick_ctrl_t;

endpackage

/* hw/rtl/stochastic_death_roulette_step_unit.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   kind, cell_req, species, draw_death, draw_pick
// out_      output     out_valid / out_ready died, picked_species, cell_population,
//                                            cell_richness, total_population, total_richness
// cfg_      input      cfg_we (no wait)      cfg_wdata: death probability
//
// An add, an out-of-range cell or a death trial that does not fire passes through the read,
// evaluate and done states from transfer to result. A firing death trial walks the species
// counts of the cell one per cycle through the running-sum unit and the count memory port,
// stops at the picked species and then updates the count, cell and species tables.
// After reset a clearing pass over all CELLS * SPECIES count addresses zeroes the count memory
// and the cell and species tables; no input transfer is taken until it ends.
// A finished result sits in the output register while the next item is taken in; the
// sequencer only stalls when it has a new result and the previous one is still waiting.
module stochastic_death_roulette_step_unit #(
  parameter int CELLS   = sdr_pkg::CELLS_DEF,
  parameter int SPECIES = sdr_pkg::SPECIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [sdr_pkg::CELL_IN_W-1:0]    in_cell_req,
  input  logic [sdr_pkg::SP_IN_W-1:0]      in_species,
  input  logic [sdr_pkg::DRAW_W-1:0]       in_draw_death,
  input  logic [sdr_pkg::DRAW_W-1:0]       in_draw_pick,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_died,
  output logic [sdr_pkg::SP_IN_W-1:0]      out_picked_species,
  output logic [sdr_pkg::CNT_W-1:0]        out_cell_population,
  output logic [sdr_pkg::RICH_W-1:0]       out_cell_richness,
  output logic [sdr_pkg::TOT_W-1:0]        out_total_population,
  output logic [sdr_pkg::RICH_W-1:0]       out_total_richness,
  input  logic                             cfg_we,
  input  logic [sdr_pkg::PROB_W-1:0]       cfg_wdata
);
  import sdr_pkg::*;

  localparam int CW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW     = $clog2(SPECIES);
  localparam int DEPTH  = CELLS * SPECIES;
  localparam int AW     = $clog2(DEPTH);
  localparam int RUN_W  = CNT_W + SW;
  localparam logic [SW-1:0] LAST_K   = SW'(SPECIES - 1);
  localparam logic [AW-1:0] LAST_CLR = AW'(DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_r;

  // The item being worked on.
  logic              kind_r;
  logic              cell_ok_r;
  logic [CW-1:0]     cell_idx_r;
  logic              sp_ok_r;
  logic [SW-1:0]     sp_idx_r;
  logic [DRAW_W-1:0] dd_r;
  logic [DRAW_W-1:0] dp_r;

  logic [AW-1:0]    base_r;
  logic [AW-1:0]    cnt_addr_r, cnt_addr_nxt;
  logic [SW-1:0]    walk_k_r, walk_k_nxt;
  logic [CNT_W-1:0] thr_hi_r, thr_hi_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;

  // Result of the current item, before the output register.
  logic              res_died_r, res_died_nxt;
  logic [SP_IN_W-1:0] res_pick_r, res_pick_nxt;
  logic [CNT_W-1:0]  res_cp_r, res_cp_nxt;
  logic [RICH_W-1:0] res_cr_r, res_cr_nxt;

  // Global state and the configuration register.
  logic [TOT_W-1:0]  pop_sum_r, pop_sum_nxt;
  logic [RICH_W-1:0] rich_sum_r, rich_sum_nxt;
  logic [PROB_W-1:0] prob_r;

  // Output register.
  logic              out_valid_r;
  logic              out_died_r;
  logic [SP_IN_W-1:0] out_pick_r;
  logic [CNT_W-1:0]  out_cp_r;
  logic [RICH_W-1:0] out_cr_r;
  logic [TOT_W-1:0]  out_tp_r;
  logic [RICH_W-1:0] out_tr_r;
  logic              out_load;

  // Cell and species tables, each with one write and one registered read port.
  logic [CNT_W-1:0]  cell_pop_mem  [CELLS];
  logic [RICH_W-1:0] cell_rich_mem [CELLS];
  logic [TOT_W-1:0]  sp_tot_mem    [SPECIES];
  logic [CNT_W-1:0]  cp_rd_r;
  logic [RICH_W-1:0] cr_rd_r;
  logic [TOT_W-1:0]  tot_rd_r;

  logic              cl_we, cl_re;
  logic [CW-1:0]     cl_waddr;
  logic [CNT_W-1:0]  cp_wdata;
  logic [RICH_W-1:0] cr_wdata;
  logic              tw_we, tr_re;
  logic [SW-1:0]     tw_addr, tr_addr;
  logic [TOT_W-1:0]  tw_data;

  // Count memory port controls.
  logic             cm_we, cm_re;
  logic [AW-1:0]    cm_waddr, cm_raddr;
  logic [CNT_W-1:0] cm_wdata;
  logic [CNT_W-1:0] cnt_rd;

  sdr_pick_ctrl_t pick_ctrl;
  logic           pick_hit;

  logic [31:0]   cell_in_ext, sp_in_ext, clr_ext, sp_ext, walk_ext;
  logic [AW-1:0] base_c;
  logic [31:0]   thr_full;
  logic          add_full;

  assign cell_in_ext = 32'(in_cell_req);
  assign sp_in_ext   = 32'(in_species);
  assign clr_ext     = 32'(clr_r);
  assign sp_ext      = 32'(sp_idx_r);
  assign walk_ext    = 32'(walk_k_r);
  assign base_c      = AW'(32'(cell_idx_r) * SPECIES);
  assign thr_full    = 32'(dp_r) * 32'(cp_rd_r);

  // An add is dropped when the species count, cell population, species total or total population is already full.
  assign add_full = (cnt_rd == CNT_MAX) || (cp_rd_r == CNT_MAX) ||
                    (tot_rd_r == TOT_MAX) || (pop_sum_r == TOT_MAX);

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  sdr_count_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_count_mem (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .re    (cm_re),
    .raddr (cm_raddr),
    .rdata (cnt_rd)
  );

  sdr_pick_acc #(
    .RUN_W (RUN_W)
  ) u_pick_acc (
    .clk   (clk),
    .ctrl  (pick_ctrl),
    .data  (cnt_rd),
    .limit (thr_hi_r),
    .hit   (pick_hit)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_addr_nxt = cnt_addr_r;
    walk_k_nxt   = walk_k_r;
    thr_hi_nxt   = thr_hi_r;
    hit_cnt_nxt  = hit_cnt_r;
    res_died_nxt = res_died_r;
    res_pick_nxt = res_pick_r;
    res_cp_nxt   = res_cp_r;
    res_cr_nxt   = res_cr_r;
    pop_sum_nxt  = pop_sum_r;
    rich_sum_nxt = rich_sum_r;

    cm_we    = 1'b0;
    cm_waddr = cnt_addr_r;
    cm_wdata = '0;
    cm_re    = 1'b0;
    cm_raddr = base_r;

    cl_we    = 1'b0;
    cl_re    = 1'b0;
    cl_waddr = cell_idx_r;
    cp_wdata = '0;
    cr_wdata = '0;
    tw_we    = 1'b0;
    tw_addr  = sp_idx_r;
    tw_data  = '0;
    tr_re    = 1'b0;
    tr_addr  = sp_idx_r;

    pick_ctrl = '0;

    unique case (state_r)
      ST_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_r;
        if (clr_ext < CELLS) begin
          cl_we    = 1'b1;
          cl_waddr = clr_r[CW-1:0];
        end
        if (clr_ext < SPECIES) begin
          tw_we   = 1'b1;
          tw_addr = clr_r[SW-1:0];
        end
        if (clr_r == LAST_CLR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        cl_re        = 1'b1;
        tr_re        = 1'b1;
        cm_re        = cell_ok_r && sp_ok_r;
        cm_raddr     = base_c + AW'(sp_idx_r);
        cnt_addr_nxt = base_c + AW'(sp_idx_r);
        state_nxt    = ST_EVAL;
      end

      ST_EVAL: begin
        res_died_nxt = 1'b0;
        res_pick_nxt = '0;
        res_cp_nxt   = cp_rd_r;
        res_cr_nxt   = cr_rd_r;
        state_nxt    = ST_DONE;
        if (!cell_ok_r) begin
          res_cp_nxt = '0;
          res_cr_nxt = '0;
        end else if (kind_r == KIND_ADD) begin
          if (sp_ok_r && !add_full) begin
            cm_we    = 1'b1;
            cm_wdata = cnt_rd + CNT_W'(1);
            cl_we    = 1'b1;
            cp_wdata = cp_rd_r + CNT_W'(1);
            cr_wdata = cr_rd_r;
            if (cnt_rd == '0 && cr_rd_r != RICH_MAX) begin
              cr_wdata = cr_rd_r + RICH_W'(1);
            end
            tw_we   = 1'b1;
            tw_data = tot_rd_r + TOT_W'(1);
            if (tot_rd_r == '0 && rich_sum_r != RICH_MAX) begin
              rich_sum_nxt = rich_sum_r + RICH_W'(1);
            end
            pop_sum_nxt  = pop_sum_r + TOT_W'(1);
            res_pick_nxt = sp_ext[SP_IN_W-1:0];
            res_cp_nxt   = cp_wdata;
            res_cr_nxt   = cr_wdata;
          end
        end else if (cp_rd_r != '0 && {1'b0, dd_r} <= prob_r) begin
          // The death fires: start the walk over the species of this cell.
          thr_hi_nxt      = thr_full[31:16];
          pick_ctrl.start = 1'b1;
          cm_re           = 1'b1;
          cm_raddr        = base_r;
          walk_k_nxt      = '0;
          state_nxt       = ST_WALK;
        end
      end

      ST_WALK: begin
        pick_ctrl.step = 1'b1;
        cm_re          = (walk_k_r != LAST_K);
        cm_raddr       = base_r + AW'(walk_k_r) + AW'(1);
        if (pick_hit) begin
          cnt_addr_nxt = base_r + AW'(walk_k_r);
          hit_cnt_nxt  = cnt_rd;
          tr_re        = 1'b1;
          tr_addr      = walk_k_r;
          state_nxt    = ST_UPD;
        end else if (walk_k_r == LAST_K) begin
          // No species found: the counts disagree, so nothing changes.
          state_nxt = ST_DONE;
        end else begin
          walk_k_nxt = walk_k_r + SW'(1);
        end
      end

      ST_UPD: begin
        tw_addr = walk_k_r;
        if (tot_rd_r != '0) begin
          tw_we   = 1'b1;
          tw_data = tot_rd_r - TOT_W'(1);
          if (tot_rd_r == TOT_W'(1) && rich_sum_r != '0) begin
            rich_sum_nxt = rich_sum_r - RICH_W'(1);
          end
        end
        cr_wdata = cr_rd_r;
        if (hit_cnt_r == CNT_W'(1) && cr_rd_r != '0) begin
          cr_wdata = cr_rd_r - RICH_W'(1);
        end
        if (hit_cnt_r != '0) begin
          cm_we    = 1'b1;
          cm_wdata = hit_cnt_r - CNT_W'(1);
        end
        if (pop_sum_r != '0) begin
          pop_sum_nxt = pop_sum_r - TOT_W'(1);
        end
        cp_wdata = cp_rd_r;
        if (cp_rd_r != '0) begin
          cp_wdata = cp_rd_r - CNT_W'(1);
        end
        cl_we        = 1'b1;
        res_died_nxt = 1'b1;
        res_pick_nxt = walk_ext[SP_IN_W-1:0];
        res_cp_nxt   = cp_wdata;
        res_cr_nxt   = cr_wdata;
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      pop_sum_r   <= '0;
      rich_sum_r  <= '0;
      prob_r      <= DEATH_PROB_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pop_sum_r  <= pop_sum_nxt;
      rich_sum_r <= rich_sum_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_we) begin
        prob_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, work and result registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r     <= in_kind;
      cell_ok_r  <= (cell_in_ext < CELLS);
      cell_idx_r <= cell_in_ext[CW-1:0];
      sp_ok_r    <= (sp_in_ext < SPECIES);
      sp_idx_r   <= sp_in_ext[SW-1:0];
      dd_r       <= in_draw_death;
      dp_r       <= in_draw_pick;
    end
    if (state_r == ST_RD) begin
      base_r <= base_c;
    end
    cnt_addr_r <= cnt_addr_nxt;
    walk_k_r   <= walk_k_nxt;
    thr_hi_r   <= thr_hi_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    res_died_r <= res_died_nxt;
    res_pick_r <= res_pick_nxt;
    res_cp_r   <= res_cp_nxt;
    res_cr_r   <= res_cr_nxt;
    if (out_load) begin
      out_died_r <= res_died_r;
      out_pick_r <= res_pick_r;
      out_cp_r   <= res_cp_r;
      out_cr_r   <= res_cr_r;
      out_tp_r   <= pop_sum_r;
      out_tr_r   <= rich_sum_r;
    end
  end

  // Cell tables.
  always_ff @(posedge clk) begin
    if (cl_we) begin
      cell_pop_mem[cl_waddr]  <= cp_wdata;
      cell_rich_mem[cl_waddr] <= cr_wdata;
    end
    if (cl_re) begin
      cp_rd_r <= cell_pop_mem[cell_idx_r];
      cr_rd_r <= cell_rich_mem[cell_idx_r];
    end
  end

  // Species totals.
  always_ff @(posedge clk) begin
    if (tw_we) begin
      sp_tot_mem[tw_addr] <= tw_data;
    end
    if (tr_re) begin
      tot_rd_r <= sp_tot_mem[tr_addr];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_died             = out_died_r;
  assign out_picked_species   = out_pick_r;
  assign out_cell_population  = out_cp_r;
  assign out_cell_richness    = out_cr_r;
  assign out_total_population = out_tp_r;
  assign out_total_richness   = out_tr_r;

endmodule

/* hw/rtl/sdr_count_mem.sv */
module sdr_count_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [sdr_pkg::CNT_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [sdr_pkg::CNT_W-1:0] rdata
);
  import sdr_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sdr_pick_acc.sv */
module sdr_pick_acc #(
  parameter int RUN_W = 23
) (
  input  logic                          clk,
  input  sdr_pkg::sdr_pick_ctrl_t       ctrl,
  input  logic [sdr_pkg::CNT_W-1:0]     data,
  input  logic [sdr_pkg::CNT_W-1:0]     limit,
  output logic                          hit
);
  import sdr_pkg::*;

  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_nxt;

  // The running sum times 65536 exceeds the threshold exactly when it exceeds
  // the upper half of the threshold.
  assign run_nxt = run_r + RUN_W'(data);
  assign hit     = ctrl.step && (run_nxt > RUN_W'(limit));

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      run_r <= '0;
    end else if (ctrl.step) begin
      run_r <= run_nxt;
    end
  end

endmodule
